>>> sv/twkb_pkg.sv
// ----------------------------------------------------------------------------
// twkb_pkg
// Shared types, codes and constants of the vertex delta varint encoder.
// ----------------------------------------------------------------------------
package twkb_pkg;

  localparam int MAX_DIMS_DEF   = 4;
  localparam int COUNT_BITS_DEF = 16;
  localparam int COORD_W        = 64;
  localparam int VAL_W          = 56;
  localparam int DELTA_W        = 57;
  localparam int ZIG_W          = 58;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 4;

  // reciprocal of ten, exact for any 32-bit dividend with a shift of 35
  localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int          RECIP_SH  = 35;

  localparam logic signed [VAL_W-1:0] BOX_TOP    = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] BOX_BOTTOM = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM_COUNT = 3'd0,
    CFG_HAS_Z     = 3'd1,
    CFG_HAS_M     = 3'd2,
    CFG_PREC_XY   = 3'd3,
    CFG_PREC_Z    = 3'd4,
    CFG_PREC_M    = 3'd5,
    CFG_BOX_EN    = 3'd6
  } cfg_index_e;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_BOX   = 2'd2
  } out_kind_e;

  typedef enum logic [2:0] {
    L_IDLE, L_MUL, L_SUM, L_PRE, L_DIV, L_SIGN, L_DONE
  } lane_state_e;

  typedef enum logic [1:0] {
    M_IDLE, M_BYTES, M_COUNT, M_BOX
  } merge_state_e;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_stat_t;

  typedef struct packed {
    logic        new_geometry;
    logic        new_array;
    logic [15:0] array_count;
    logic [2:0]  min_points;
    logic        last_point;
  } item_flags_t;

  function automatic logic [23:0] pow_ten(input logic [2:0] k);
    logic [23:0] r;
    case (k)
      3'd0:    r = 24'd1;
      3'd1:    r = 24'd10;
      3'd2:    r = 24'd100;
      3'd3:    r = 24'd1000;
      3'd4:    r = 24'd10000;
      3'd5:    r = 24'd100000;
      3'd6:    r = 24'd1000000;
      3'd7:    r = 24'd10000000;
      default: r = 24'd1;
    endcase
    return r;
  endfunction

endpackage

>>> sv/twkb_scale_lane.sv
// ----------------------------------------------------------------------------
// twkb_scale_lane
// Scales one Q31.32 coordinate by a decimal power and rounds half away
// from zero; negative powers divide by ten once per cycle.
// ----------------------------------------------------------------------------
module twkb_scale_lane import twkb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [COORD_W-1:0]      raw_i,
  input  logic signed [3:0]       prec_i,
  input  logic                    take_i,
  output lane_stat_t              stat_o,
  output logic signed [VAL_W-1:0] scaled_o
);

  lane_state_e state_q, state_d;

  logic [COORD_W-1:0] mag_q;
  logic               neg_q;
  logic [2:0]         pow_q;
  logic [55:0]        hi_q, lo_q;
  logic [31:0]        t_q;
  logic [2:0]         cnt_q;
  logic [VAL_W-1:0]   q_q;
  logic [VAL_W-1:0]   res_q;

  logic [3:0]         neg_prec;
  logic [56:0]        lo_round;
  logic [COORD_W-1:0] pre_sum;
  logic [63:0]        div_prod;

  assign neg_prec = 4'(~prec_i + 4'd1);
  assign lo_round = {1'b0, lo_q} + 57'h0_8000_0000;
  assign pre_sum  = mag_q + ({40'd0, pow_ten(pow_q)} << 31);
  assign div_prod = {32'd0, t_q} * {32'd0, RECIP_TEN};

  always_comb begin
    state_d = state_q;
    case (state_q)
      L_IDLE: begin
        if (start_i) state_d = prec_i[3] ? L_PRE : L_MUL;
      end
      L_MUL:  state_d = L_SUM;
      L_SUM:  state_d = L_SIGN;
      L_PRE:  state_d = L_DIV;
      L_DIV: begin
        if (cnt_q == 3'd1) state_d = L_SIGN;
      end
      L_SIGN: state_d = L_DONE;
      L_DONE: begin
        if (take_i) state_d = L_IDLE;
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      L_IDLE: begin
        if (start_i) begin
          mag_q <= raw_i[COORD_W-1] ? (~raw_i + 64'd1) : raw_i;
          neg_q <= raw_i[COORD_W-1];
          pow_q <= prec_i[3] ? neg_prec[2:0] : prec_i[2:0];
        end
      end
      L_MUL: begin
        hi_q <= {24'd0, mag_q[63:32]} * {32'd0, pow_ten(pow_q)};
        lo_q <= {24'd0, mag_q[31:0]} * {32'd0, pow_ten(pow_q)};
      end
      L_SUM: q_q <= hi_q + 56'(lo_round >> 32);
      L_PRE: begin
        t_q   <= pre_sum[63:32];
        cnt_q <= pow_q;
      end
      L_DIV: begin
        t_q   <= 32'(div_prod >> RECIP_SH);
        q_q   <= 56'(div_prod >> RECIP_SH);
        cnt_q <= cnt_q - 3'd1;
      end
      L_SIGN: res_q <= neg_q ? (~q_q + 56'd1) : q_q;
      default: ;
    endcase
  end

  assign stat_o.idle = (state_q == L_IDLE);
  assign stat_o.done = (state_q == L_DONE);
  assign scaled_o    = res_q;

endmodule

>>> sv/twkb_merge.sv
// ----------------------------------------------------------------------------
// twkb_merge
// Forms deltas from the lane results, drops repeated vertices, keeps the
// accumulators and box, and serializes zigzag varint bytes and summaries.
// ----------------------------------------------------------------------------
module twkb_merge import twkb_pkg::*; #(
  parameter int MAX_DIMS   = MAX_DIMS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    lanes_done_i,
  input  logic signed [VAL_W-1:0] scaled_i [MAX_DIMS],
  input  item_flags_t             flags_i,
  input  logic [2:0]              dim_count_i,
  input  logic                    box_enable_i,
  output logic                    take_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              kind_o,
  output logic [7:0]              data_byte_o,
  output logic [15:0]             kept_count_o,
  output logic [1:0]              dim_index_o,
  output logic signed [VAL_W-1:0] box_low_o,
  output logic signed [VAL_W-1:0] box_high_o,
  output logic                    final_res_o
);

  localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  merge_state_e state_q, state_d;

  logic signed [VAL_W-1:0] acc_q [MAX_DIMS];
  logic signed [VAL_W-1:0] bmin_q [MAX_DIMS];
  logic signed [VAL_W-1:0] bmax_q [MAX_DIMS];
  logic [COUNT_BITS-1:0]   rem_q, kept_q;
  logic [2:0]              floor_q;
  logic                    first_q;
  logic                    last_q;
  logic [ZIG_W-1:0]        zig_q [MAX_DIMS];
  logic [ZIG_W-1:0]        sh_q;
  logic [DIM_W-1:0]        dim_q;

  logic                    out_valid_q;
  out_kind_e               kind_q;
  logic [7:0]              byte_q;
  logic [15:0]             cnt_q;
  logic [1:0]              didx_q;
  logic signed [VAL_W-1:0] lo_q, hi_q;
  logic                    fin_q;

  logic signed [VAL_W-1:0]   acc_eff [MAX_DIMS];
  logic signed [VAL_W-1:0]   bmin_eff [MAX_DIMS];
  logic signed [VAL_W-1:0]   bmax_eff [MAX_DIMS];
  logic signed [DELTA_W-1:0] delta [MAX_DIMS];
  logic [ZIG_W-1:0]          zig [MAX_DIMS];
  logic                      in_use [MAX_DIMS];
  logic                      all_zero;
  logic [COUNT_BITS-1:0]     rem_eff, kept_eff;
  logic [2:0]                floor_eff;
  logic                      first_eff;
  logic                      drop;
  logic                      adv;
  logic                      last_dim;
  logic                      more_bytes;

  logic                      emit;
  out_kind_e                 e_kind;
  logic [7:0]                e_byte;
  logic                      e_final;

  assign take_o     = lanes_done_i && (state_q == M_IDLE);
  assign adv        = !out_valid_q || out_ready_i;
  assign last_dim   = (3'(dim_q) == (dim_count_i - 3'd1));
  assign more_bytes = |sh_q[ZIG_W-1:7];

  always_comb begin
    all_zero = 1'b1;
    for (int j = 0; j < MAX_DIMS; j++) begin
      in_use[j]   = (3'(j) < dim_count_i);
      acc_eff[j]  = flags_i.new_geometry ? '0 : acc_q[j];
      bmin_eff[j] = flags_i.new_geometry ? BOX_TOP : bmin_q[j];
      bmax_eff[j] = flags_i.new_geometry ? BOX_BOTTOM : bmax_q[j];
      delta[j]    = {scaled_i[j][VAL_W-1], scaled_i[j]} - {acc_eff[j][VAL_W-1], acc_eff[j]};
      zig[j]      = {delta[j], 1'b0} ^ {ZIG_W{delta[j][DELTA_W-1]}};
      if (in_use[j] && (delta[j] != '0)) all_zero = 1'b0;
    end
    rem_eff   = flags_i.new_array ? COUNT_BITS'(flags_i.array_count) : rem_q;
    kept_eff  = flags_i.new_array ? '0 : kept_q;
    floor_eff = flags_i.new_array ? flags_i.min_points : floor_q;
    first_eff = flags_i.new_array ? 1'b1 : first_q;
    drop      = !first_eff && all_zero && (rem_eff > COUNT_BITS'(floor_eff));
  end

  always_comb begin
    state_d = state_q;
    emit    = 1'b0;
    e_kind  = KIND_BYTE;
    e_byte  = '0;
    e_final = 1'b0;
    case (state_q)
      M_IDLE: begin
        if (take_o) begin
          if (!drop) state_d = M_BYTES;
          else if (flags_i.last_point) state_d = M_COUNT;
        end
      end
      M_BYTES: begin
        emit    = 1'b1;
        e_byte  = more_bytes ? {1'b1, sh_q[6:0]} : sh_q[7:0];
        e_final = !more_bytes && last_dim && !last_q;
        if (adv && !more_bytes && last_dim) state_d = last_q ? M_COUNT : M_IDLE;
      end
      M_COUNT: begin
        emit    = 1'b1;
        e_kind  = KIND_COUNT;
        e_final = !box_enable_i;
        if (adv) state_d = box_enable_i ? M_BOX : M_IDLE;
      end
      M_BOX: begin
        emit    = 1'b1;
        e_kind  = KIND_BOX;
        e_final = last_dim;
        if (adv && last_dim) state_d = M_IDLE;
      end
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= M_IDLE;
      rem_q       <= '0;
      kept_q      <= '0;
      floor_q     <= 3'd1;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
      for (int j = 0; j < MAX_DIMS; j++) begin
        acc_q[j]  <= '0;
        bmin_q[j] <= BOX_TOP;
        bmax_q[j] <= BOX_BOTTOM;
      end
    end else begin
      state_q <= state_d;
      if (adv) out_valid_q <= emit;
      if (take_o) begin
        floor_q <= floor_eff;
        if (drop) begin
          rem_q   <= rem_eff - 1'b1;
          kept_q  <= kept_eff;
          first_q <= first_eff;
        end else begin
          rem_q   <= rem_eff;
          kept_q  <= kept_eff + 1'b1;
          first_q <= 1'b0;
        end
        for (int j = 0; j < MAX_DIMS; j++) begin
          acc_q[j]  <= acc_eff[j];
          bmin_q[j] <= bmin_eff[j];
          bmax_q[j] <= bmax_eff[j];
          if (!drop && in_use[j]) begin
            acc_q[j] <= scaled_i[j];
            if (box_enable_i) begin
              if (scaled_i[j] < bmin_eff[j]) bmin_q[j] <= scaled_i[j];
              if (scaled_i[j] > bmax_eff[j]) bmax_q[j] <= scaled_i[j];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      last_q <= flags_i.last_point;
      dim_q  <= '0;
      sh_q   <= zig[0];
      for (int j = 0; j < MAX_DIMS; j++) zig_q[j] <= zig[j];
    end else if (adv) begin
      case (state_q)
        M_BYTES: begin
          if (more_bytes) begin
            sh_q <= sh_q >> 7;
          end else if (!last_dim) begin
            dim_q <= DIM_W'(dim_q + 1'b1);
            sh_q  <= zig_q[DIM_W'(dim_q + 1'b1)];
          end else begin
            dim_q <= '0;
          end
        end
        M_COUNT: dim_q <= '0;
        M_BOX:   dim_q <= DIM_W'(dim_q + 1'b1);
        default: ;
      endcase
    end
    if (adv && emit) begin
      kind_q <= e_kind;
      byte_q <= e_byte;
      cnt_q  <= (e_kind == KIND_COUNT) ? 16'(kept_q) : '0;
      didx_q <= (e_kind == KIND_BOX) ? 2'(dim_q) : '0;
      lo_q   <= (e_kind == KIND_BOX) ? bmin_q[dim_q] : '0;
      hi_q   <= (e_kind == KIND_BOX) ? bmax_q[dim_q] : '0;
      fin_q  <= e_final;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign data_byte_o  = byte_q;
  assign kept_count_o = cnt_q;
  assign dim_index_o  = didx_q;
  assign box_low_o    = lo_q;
  assign box_high_o   = hi_q;
  assign final_res_o  = fin_q;

endmodule

>>> sv/twkb_point_delta_varint_encoder_unit.sv
// ----------------------------------------------------------------------------
// twkb_point_delta_varint_encoder_unit
// Vertex delta encoder: scaled, rounded coordinates go out as zigzag
// varint deltas, with kept-point count and optional box per array.
// ----------------------------------------------------------------------------
// One scaling lane per dimension works on a vertex while the merge stage is
// still sending the bytes of the one before. A lane multiplies, rounds and
// signs for a non-negative precision; for precision -k it adds half the
// divisor, then divides by ten k times (one multiply by the reciprocal of
// ten per cycle) and signs. The merge stage forms the deltas and sends its
// results as the output takes them: one per varint byte (one to nine per
// dimension), plus the count and box results on the last vertex of an
// array. With two-byte deltas in two dimensions, the byte output sets the rate.
// ----------------------------------------------------------------------------
module twkb_point_delta_varint_encoder_unit import twkb_pkg::*; #(
  parameter int MAX_DIMS   = MAX_DIMS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [63:0]      coord_x_i,
  input  logic signed [63:0]      coord_y_i,
  input  logic signed [63:0]      coord_third_i,
  input  logic signed [63:0]      coord_fourth_i,
  input  logic                    new_geometry_i,
  input  logic                    new_array_i,
  input  logic [15:0]             array_count_i,
  input  logic [2:0]              min_points_i,
  input  logic                    last_point_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              kind_o,
  output logic [7:0]              data_byte_o,
  output logic [15:0]             kept_count_o,
  output logic [1:0]              dim_index_o,
  output logic signed [55:0]      box_low_o,
  output logic signed [55:0]      box_high_o,
  output logic                    final_res_o
);

  logic [2:0]        dim_count_q;
  logic              has_z_q, has_m_q, box_en_q;
  logic signed [3:0] prec_xy_q;
  logic [2:0]        prec_z_q, prec_m_q;

  logic [2:0]        nd;
  logic signed [3:0] prec_xy;
  logic signed [3:0] prec_third, prec_fourth;
  logic              accept;
  logic              take;
  logic              all_idle, all_done;
  item_flags_t       flags_q;

  logic [COORD_W-1:0]      coord_a [4];
  lane_stat_t              stat [MAX_DIMS];
  logic signed [VAL_W-1:0] scaled [MAX_DIMS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_count_q <= 3'd2;
      has_z_q     <= 1'b0;
      has_m_q     <= 1'b0;
      prec_xy_q   <= '0;
      prec_z_q    <= '0;
      prec_m_q    <= '0;
      box_en_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DIM_COUNT: dim_count_q <= cfg_data_i[2:0];
        CFG_HAS_Z:     has_z_q     <= cfg_data_i[0];
        CFG_HAS_M:     has_m_q     <= cfg_data_i[0];
        CFG_PREC_XY:   prec_xy_q   <= cfg_data_i;
        CFG_PREC_Z:    prec_z_q    <= cfg_data_i[2:0];
        CFG_PREC_M:    prec_m_q    <= cfg_data_i[2:0];
        CFG_BOX_EN:    box_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (dim_count_q < 3'd2) nd = 3'd2;
    else if (dim_count_q > 3'(MAX_DIMS)) nd = 3'(MAX_DIMS);
    else nd = dim_count_q;
  end

  // minus eight acts as minus seven
  assign prec_xy     = (prec_xy_q == 4'b1000) ? 4'b1001 : prec_xy_q;
  assign prec_third  = (has_m_q && !has_z_q) ? {1'b0, prec_m_q} : {1'b0, prec_z_q};
  assign prec_fourth = {1'b0, prec_m_q};

  assign coord_a[0] = coord_x_i;
  assign coord_a[1] = coord_y_i;
  assign coord_a[2] = coord_third_i;
  assign coord_a[3] = coord_fourth_i;

  always_comb begin
    all_idle = 1'b1;
    all_done = 1'b1;
    for (int j = 0; j < MAX_DIMS; j++) begin
      all_idle = all_idle & stat[j].idle;
      all_done = all_done & stat[j].done;
    end
  end

  assign in_ready_o = all_idle;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      flags_q.new_geometry <= new_geometry_i;
      flags_q.new_array    <= new_array_i;
      flags_q.array_count  <= array_count_i;
      flags_q.min_points   <= min_points_i;
      flags_q.last_point   <= last_point_i;
    end
  end

  for (genvar j = 0; j < MAX_DIMS; j++) begin : g_lane
    logic signed [3:0] lane_prec;
    if (j < 2) begin : g_xy
      assign lane_prec = prec_xy;
    end else if (j == 2) begin : g_third
      assign lane_prec = prec_third;
    end else begin : g_fourth
      assign lane_prec = prec_fourth;
    end

    twkb_scale_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .start_i  (accept),
      .raw_i    (coord_a[j]),
      .prec_i   (lane_prec),
      .take_i   (take),
      .stat_o   (stat[j]),
      .scaled_o (scaled[j])
    );
  end

  twkb_merge #(
    .MAX_DIMS   (MAX_DIMS),
    .COUNT_BITS (COUNT_BITS)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lanes_done_i (all_done),
    .scaled_i     (scaled),
    .flags_i      (flags_q),
    .dim_count_i  (nd),
    .box_enable_i (box_en_q),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .data_byte_o  (data_byte_o),
    .kept_count_o (kept_count_o),
    .dim_index_o  (dim_index_o),
    .box_low_o    (box_low_o),
    .box_high_o   (box_high_o),
    .final_res_o  (final_res_o)
  );

endmodule

>>> tb/tb_twkb_point_delta_varint_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_twkb_point_delta_varint_encoder_unit
// Drives vertices through the delta varint encoder under several register
// settings and checks every byte, count and box result against a predictor.
// ----------------------------------------------------------------------------
module tb_twkb_point_delta_varint_encoder_unit;
  import twkb_pkg::*;

  typedef struct {
    logic [63:0] cx, cy, c3, c4;
    bit          ng, na;
    bit [15:0]   cnt;
    bit [2:0]    mp;
    bit          lp;
  } vertex_t;

  typedef struct {
    out_kind_e   kind;
    bit [7:0]    byte_v;
    bit [15:0]   kept;
    bit [1:0]    dim;
    bit [55:0]   lo, hi;
    bit          fin;
  } enc_res_t;

  typedef struct {
    vertex_t     v;
    int          nb;     // typed byte count, -1 means take the predictor
    bit [7:0]    b0, b1;
    bit          has_cnt;
    bit [15:0]   cnt;
  } dir_row_t;

  logic clk_i = 0, rst_ni = 0;
  logic cfg_valid_i = 0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 0, out_ready_i = 0;
  logic signed [63:0] coord_x_i = 0, coord_y_i = 0, coord_third_i = 0, coord_fourth_i = 0;
  logic new_geometry_i = 0, new_array_i = 0, last_point_i = 0;
  logic [15:0] array_count_i = 0;
  logic [2:0] min_points_i = 0;
  logic cfg_ready_o, in_ready_o, out_valid_o, final_res_o;
  logic [1:0] kind_o, dim_index_o;
  logic [7:0] data_byte_o;
  logic [15:0] kept_count_o;
  logic signed [55:0] box_low_o, box_high_o;

  twkb_point_delta_varint_encoder_unit dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // predictor state
  bit [2:0] cf_dims = 2;
  bit cf_z, cf_m, cf_box;
  int cf_pxy;
  bit [2:0] cf_pz, cf_pm;
  longint signed acc[4], bmin[4], bmax[4];
  bit [15:0] pts_left, pts_kept;
  bit [2:0] floor_pts = 1;
  bit first_pend = 1;

  enc_res_t expected_q[$], pred_q[$];
  dir_row_t dir_q[$];
  int errors = 0, items_sent = 0, results_seen = 0;
  bit quiet = 0, hold_req = 0;

  task automatic report(string what, longint got, longint want);
    errors++;
    if (errors <= 40)
      $display("result %0d: %s got %0h expected %0h", results_seen, what, got, want);
  endtask

  function automatic longint signed scale_q32(logic [63:0] raw, int p);
    bit neg;
    bit [63:0] mag, f, q, d;
    neg = raw[63];
    mag = neg ? -raw : raw;
    f = 1;
    for (int i = 0; i < (p < 0 ? -p : p); i++) f = f * 10;
    if (p >= 0) begin
      q = (mag >> 32) * f + ((((mag & 64'hFFFF_FFFF) * f) + 64'h8000_0000) >> 32);
    end else begin
      d = f << 32;
      q = (mag + (d >> 1)) / d;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic void clear_geom();
    for (int i = 0; i < 4; i++) begin
      acc[i] = 0;
      bmin[i] = 56'sh7F_FFFF_FFFF_FFFF;
      bmax[i] = -(longint'(1) <<< 55);
    end
  endfunction

  function automatic void push_res(out_kind_e k, bit [7:0] b, bit [15:0] c, bit [1:0] d,
                                   longint signed lo, longint signed hi);
    enc_res_t r;
    r.kind = k; r.byte_v = b; r.kept = c; r.dim = d;
    r.lo = lo[55:0]; r.hi = hi[55:0]; r.fin = 0;
    pred_q.push_back(r);
  endfunction

  // fills pred_q with the results of one vertex and advances the state
  function automatic void encode_vertex(vertex_t v);
    longint signed dl[4];
    logic [63:0] crd[4];
    bit [63:0] z;
    int nd, p;
    bit all_zero;
    pred_q.delete();
    nd = cf_dims < 2 ? 2 : (cf_dims > 4 ? 4 : cf_dims);
    crd[0] = v.cx; crd[1] = v.cy; crd[2] = v.c3; crd[3] = v.c4;
    all_zero = 1;
    if (v.ng) clear_geom();
    if (v.na) begin
      pts_left = v.cnt; pts_kept = 0; floor_pts = v.mp; first_pend = 1;
    end
    for (int j = 0; j < nd; j++) begin
      if (j < 2) p = cf_pxy < -7 ? -7 : cf_pxy;
      else if (j == 2) p = (cf_m && !cf_z) ? cf_pm : cf_pz;
      else p = cf_pm;
      dl[j] = scale_q32(crd[j], p) - acc[j];
      if (dl[j] != 0) all_zero = 0;
    end
    if (!first_pend && all_zero && pts_left > floor_pts) begin
      pts_left--;
    end else begin
      pts_kept++;
      first_pend = 0;
      for (int j = 0; j < nd; j++) begin
        acc[j] += dl[j];
        z = (dl[j] << 1) ^ (dl[j] < 0 ? '1 : 64'd0);
        while (z >= 128) begin
          push_res(KIND_BYTE, {1'b1, z[6:0]}, 0, 0, 0, 0);
          z >>= 7;
        end
        push_res(KIND_BYTE, z[7:0], 0, 0, 0, 0);
        if (cf_box) begin
          if (acc[j] > bmax[j]) bmax[j] = acc[j];
          if (acc[j] < bmin[j]) bmin[j] = acc[j];
        end
      end
    end
    if (v.lp) begin
      push_res(KIND_COUNT, 0, pts_kept, 0, 0, 0);
      if (cf_box)
        for (int j = 0; j < nd; j++) push_res(KIND_BOX, 0, 0, 2'(j), bmin[j], bmax[j]);
    end
    if (pred_q.size() > 0) pred_q[pred_q.size()-1].fin = 1;
  endfunction

  task automatic write_reg(cfg_index_e idx, logic [3:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    case (idx)
      CFG_DIM_COUNT: cf_dims = val[2:0];
      CFG_HAS_Z:     cf_z = val[0];
      CFG_HAS_M:     cf_m = val[0];
      CFG_PREC_XY:   cf_pxy = val[3] ? int'(val) - 16 : int'(val);
      CFG_PREC_Z:    cf_pz = val[2:0];
      CFG_PREC_M:    cf_pm = val[2:0];
      CFG_BOX_EN:    cf_box = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid_i <= 0;
    wait (expected_q.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_all(int dc, int hz, int hm, int pxy, int pz, int pm, int bx);
    wait_idle();
    write_reg(CFG_DIM_COUNT, dc[3:0]);
    write_reg(CFG_HAS_Z, hz[3:0]);
    write_reg(CFG_HAS_M, hm[3:0]);
    write_reg(CFG_PREC_XY, pxy[3:0]);
    write_reg(CFG_PREC_Z, pz[3:0]);
    write_reg(CFG_PREC_M, pm[3:0]);
    write_reg(CFG_BOX_EN, bx[3:0]);
  endtask

  // drives one vertex and queues its results; typed rows replace the bytes
  task automatic send_vertex(vertex_t v, dir_row_t row, bit typed);
    int g;
    enc_res_t r;
    g = quiet ? 0 : $urandom_range(0, 11);
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1;
    coord_x_i <= v.cx; coord_y_i <= v.cy; coord_third_i <= v.c3; coord_fourth_i <= v.c4;
    new_geometry_i <= v.ng; new_array_i <= v.na; array_count_i <= v.cnt;
    min_points_i <= v.mp; last_point_i <= v.lp;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    encode_vertex(v);
    if (typed) begin
      pred_q.delete();
      r = '{KIND_BYTE, 0, 0, 0, 0, 0, 0};
      for (int i = 0; i < row.nb; i++) begin
        r.byte_v = (i == 0) ? row.b0 : row.b1;
        pred_q.push_back(r);
      end
      if (row.has_cnt) begin
        r.kind = KIND_COUNT; r.byte_v = 0; r.kept = row.cnt;
        pred_q.push_back(r);
      end
      pred_q[pred_q.size()-1].fin = 1;
    end
    foreach (pred_q[i]) expected_q.push_back(pred_q[i]);
  endtask

  function automatic vertex_t mk(logic [63:0] x, y, t, f, bit ng, na,
                                  bit [15:0] c, bit [2:0] mp, bit lp);
    vertex_t v;
    v.cx = x; v.cy = y; v.c3 = t; v.c4 = f;
    v.ng = ng; v.na = na; v.cnt = c; v.mp = mp; v.lp = lp;
    return v;
  endfunction

  task automatic row(vertex_t v, int nb = -1, bit [7:0] b0 = 0, bit [7:0] b1 = 0,
                     bit has_cnt = 0, bit [15:0] cnt = 0);
    dir_row_t r;
    r.v = v; r.nb = nb; r.b0 = b0; r.b1 = b1; r.has_cnt = has_cnt; r.cnt = cnt;
    dir_q.push_back(r);
  endtask

  function automatic logic [63:0] near_coord(logic [63:0] base);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return base;
      4, 5, 6:    return base + longint'($signed($urandom_range(0, 32'hFFFF_FFFF))) * 16;
      7, 8:       return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom()), 32'($urandom())};
      default:    return {32'($urandom()), 32'($urandom())};
    endcase
  endfunction

  task automatic random_phase(int target);
    vertex_t v;
    dir_row_t none;
    int n, sent;
    logic [63:0] b[4];
    sent = 0;
    for (int i = 0; i < 4; i++) b[i] = {32'($urandom_range(0, 255)), 32'($urandom())};
    while (sent < target) begin
      if ($urandom_range(0, 7) == 0) begin
        // noise: fully random flags and coordinates
        v = mk({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, $urandom, $urandom, $urandom, $urandom, $urandom);
        send_vertex(v, none, 0);
        sent++;
      end else begin
        n = $urandom_range(1, 8);
        v.mp = ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
        v.cnt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(n);
        v.ng = $urandom_range(0, 3) == 0;
        for (int k = 0; k < n; k++) begin
          for (int i = 0; i < 4; i++) b[i] = near_coord(b[i]);
          v.cx = b[0]; v.cy = b[1]; v.c3 = b[2]; v.c4 = b[3];
          v.na = (k == 0); v.lp = (k == n - 1);
          send_vertex(v, none, 0);
          v.ng = 0;
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    enc_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report("unexpected result kind", kind_o, 0);
      end else begin
        e = expected_q.pop_front();
        if (kind_o != e.kind) report("kind", kind_o, e.kind);
        if (data_byte_o != e.byte_v) report("data_byte", data_byte_o, e.byte_v);
        if (kept_count_o != e.kept) report("kept_count", kept_count_o, e.kept);
        if (dim_index_o != e.dim) report("dim_index", dim_index_o, e.dim);
        if (box_low_o != e.lo) report("box_low", box_low_o, e.lo);
        if (box_high_o != e.hi) report("box_high", box_high_o, e.hi);
        if (final_res_o != e.fin) report("final_res", final_res_o, e.fin);
      end
    end
  end

  // receiver side with random stalls and one long hold-off
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 0;
        repeat (400) @(posedge clk_i);
        hold_req = 0;
      end
      n = quiet ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
        out_ready_i <= 0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  localparam logic [63:0] ONE = 64'h1_0000_0000;
  localparam logic [63:0] CMIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] CMAX = 64'h7FFF_FFFF_FFFF_FFFF;

  initial begin
    int dc[8] = '{2, 4, 3, 0, 7, 4, 3, 1};
    int hz[8] = '{0, 1, 0, 1, 0, 1, 0, 1};
    int hm[8] = '{0, 1, 1, 0, 0, 1, 1, 1};
    int px[8] = '{0, 7, -7, -8, 3, -3, 2, -1};
    int pz[8] = '{0, 7, 0, 3, 2, 7, 0, 4};
    int pm[8] = '{0, 7, 5, 0, 7, 1, 7, 4};
    int bx[8] = '{1, 1, 1, 0, 1, 0, 1, 1};
    vertex_t a;
    clear_geom();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;

    // reset settings: no array started yet, then simple typed cases and extremes
    row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 2, 8'h00, 8'h00);
    row(mk(0, 0, 0, 0, 0, 1, 1, 1, 1), 2, 8'h00, 8'h00, 1, 16'd1);
    row(mk(ONE, -ONE, 0, 0, 1, 1, 1, 1, 1), 2, 8'h02, 8'h01, 1, 16'd1);
    row(mk(CMIN, CMAX, 0, 0, 1, 1, 2, 1, 0));
    row(mk(CMAX, CMIN, 0, 0, 0, 0, 0, 0, 1));
    foreach (dir_q[i]) send_vertex(dir_q[i].v, dir_q[i], dir_q[i].nb >= 0);
    dir_q.delete();

    // widest settings: extremes, box, dropped repeats down to the floor
    set_all(4, 1, 1, 7, 7, 7, 1);
    a = mk(ONE * 3 + 64'h8000_0000, -ONE * 5, ONE, -ONE, 1, 1, 5, 2, 0);
    row(mk(CMAX, CMAX, CMAX, CMAX, 1, 1, 2, 1, 0));
    row(mk(CMIN, CMIN, CMIN, CMIN, 0, 0, 0, 0, 1));
    row(a);
    a.ng = 0; a.na = 0;
    row(a);
    row(a);
    row(a);
    a.lp = 1;
    row(a);
    row(mk(0, 0, 0, 0, 0, 1, 3, 3, 0));
    row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    row(mk(64'h7FFF, 64'h8000_0000, -64'h8000_0000, 1, 0, 0, 0, 0, 1));
    row(mk(ONE, ONE, ONE, ONE, 0, 1, 16'hFFFF, 3'd7, 1));
    row(mk(ONE, ONE, ONE, ONE, 0, 1, 0, 0, 1));
    foreach (dir_q[i]) send_vertex(dir_q[i].v, dir_q[i], 0);

    for (int ph = 0; ph < 8; ph++) begin
      set_all(dc[ph], hz[ph], hm[ph], px[ph], pz[ph], pm[ph], bx[ph]);
      quiet = (ph == 2 || ph == 6);
      if (ph == 3) hold_req = 1;
      random_phase(28);
      if (ph == 5) begin
        in_valid_i <= 0;
        wait (expected_q.size() == 0);
      end
      random_phase(28);
    end
    in_valid_i <= 0;
    wait (expected_q.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("sent %0d vertices over 10 register settings, checked %0d results",
             items_sent, results_seen);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
